// ===== hdl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants and control types of the bitmap segment plotter.
// ----------------------------------------------------------------------------
package bsp_pkg;

   // Canvas size. ROWS may be 1..16, COLS may be 1..64.
   localparam int ROWS = 16;
   localparam int COLS = 64;

   // Width of the input coordinate fields and of the emitted row word.
   localparam int CoordW   = 8;
   localparam int CellW    = 64;
   localparam int RowNumW  = 4;
   // Enough bits for an index into a 64-bit row word, or for the value 64.
   localparam int CellIdxW = 7;

   // Coordinates that passed the range check hold 0..ROWS and 0..COLS.
   localparam int RowW    = $clog2(ROWS + 1);
   localparam int ColW    = $clog2(COLS + 1);
   localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [RowIdxW-1:0] LastRow = RowIdxW'(ROWS - 1);

   typedef struct packed {
      logic                draw;     // apply the item on the request channel
      logic                load;     // copy one canvas row into the result register
      logic                clear;    // clear the whole canvas
      logic [RowIdxW-1:0]  row_sel;  // row read by a load
   } cmd_type;

   typedef struct packed {
      logic dump;                    // the offered item has an invalid coordinate
   } status_type;

endpackage

// ===== hdl/bsp_if.sv =====
// ----------------------------------------------------------------------------
// bsp_req_if / bsp_rsp_if
// Valid/ready channels of the bitmap segment plotter.
// ----------------------------------------------------------------------------
interface bsp_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] row_a;
   logic signed [7:0] col_a;
   logic signed [7:0] row_b;
   logic signed [7:0] col_b;

   modport source (output valid, output row_a, output col_a, output row_b,
                   output col_b, input ready);
   modport sink   (input valid, input row_a, input col_a, input row_b,
                   input col_b, output ready);
endinterface

interface bsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  row_number;
   logic [63:0] row_cells;
   logic        last_row;

   modport source (output valid, output row_number, output row_cells,
                   output last_row, input ready);
   modport sink   (input valid, input row_number, input row_cells,
                   input last_row, output ready);
endinterface

// ===== hdl/bitmap_segment_plotter_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_segment_plotter_top
// Bitmap segment plotter: draws axis-aligned segments on a one-bit canvas.
// ----------------------------------------------------------------------------
// Each request item carries two endpoints. An item whose four coordinates are
// all in range draws a horizontal or vertical segment (clipped to the canvas)
// when its endpoints share a row or a column and a is not past b, else nothing;
// it produces no result, and the next item can follow in the next cycle. An
// item with any coordinate out of range starts a dump: the canvas rows go out
// as ROWS result items, row 0 first, the last one marked with last_row, after
// which the canvas is cleared. The dump reads the canvas one row per cycle
// through its single read port while the result register is free, and holds
// req_ready low until the last row is loaded. The canvas is cleared by reset.
module bitmap_segment_plotter_top (
   input  logic         clock,
   input  logic         reset,
   bsp_req_if.sink      req_chan,
   bsp_rsp_if.source    rsp_chan
);
   import bsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .row_a      (req_chan.row_a),
      .col_a      (req_chan.col_a),
      .row_b      (req_chan.row_b),
      .col_b      (req_chan.col_b),
      .cmd        (cmd),
      .status     (status),
      .row_number (rsp_chan.row_number),
      .row_cells  (rsp_chan.row_cells),
      .last_row   (rsp_chan.last_row)
   );

endmodule

// ===== hdl/bsp_datapath.sv =====
// ----------------------------------------------------------------------------
// bsp_datapath
// Canvas register file, segment decode and result payload register.
// ----------------------------------------------------------------------------
module bsp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [7:0]             row_a,
   input  logic signed [7:0]             col_a,
   input  logic signed [7:0]             row_b,
   input  logic signed [7:0]             col_b,
   input  bsp_pkg::cmd_type              cmd,
   output bsp_pkg::status_type           status,
   output logic [bsp_pkg::RowNumW-1:0]   row_number,
   output logic [bsp_pkg::CellW-1:0]     row_cells,
   output logic                          last_row
);
   import bsp_pkg::*;

   logic [CellW-1:0]    canvas_ff [ROWS];
   logic [CellW-1:0]    canvas_in [ROWS];
   logic [RowNumW-1:0]  row_number_ff;
   logic [CellW-1:0]    row_cells_ff;
   logic                last_row_ff;

   logic                ok_a, ok_b;
   logic [RowW-1:0]     ra, rb;
   logic [ColW-1:0]     ca, cb, hi;
   logic                horiz, vert;
   logic [CellW-1:0]    span, bit_mask;

   // A coordinate is in range when it is not negative and not above the limit.
   assign ok_a = !row_a[CoordW-1] && ({1'b0, row_a[CoordW-2:0]} <= CoordW'(ROWS)) &&
                 !col_a[CoordW-1] && ({1'b0, col_a[CoordW-2:0]} <= CoordW'(COLS));
   assign ok_b = !row_b[CoordW-1] && ({1'b0, row_b[CoordW-2:0]} <= CoordW'(ROWS)) &&
                 !col_b[CoordW-1] && ({1'b0, col_b[CoordW-2:0]} <= CoordW'(COLS));
   assign status.dump = !(ok_a && ok_b);

   assign ra = row_a[RowW-1:0];
   assign rb = row_b[RowW-1:0];
   assign ca = col_a[ColW-1:0];
   assign cb = col_b[ColW-1:0];

   assign horiz = (ra == rb) && (ca <= cb);
   assign vert  = !horiz && (ca == cb) && (ra <= rb);
   assign hi    = (cb < ColW'(COLS)) ? cb : ColW'(COLS - 1);

   assign span     = ({CellW{1'b1}} << CellIdxW'(ca)) &
                     ({CellW{1'b1}} >> (CellIdxW'(CellW - 1) - CellIdxW'(hi)));
   assign bit_mask = CellW'(1) << CellIdxW'(ca);

   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         canvas_in[i] = canvas_ff[i];
         if (cmd.clear) begin
            canvas_in[i] = '0;
         end else if (cmd.draw && (ca < ColW'(COLS))) begin
            if (horiz && (ra == RowW'(i))) begin
               canvas_in[i] = canvas_ff[i] | span;
            end else if (vert && (ra <= RowW'(i)) && (RowW'(i) <= rb)) begin
               canvas_in[i] = canvas_ff[i] | bit_mask;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROWS; i++) begin
         if (reset) begin
            canvas_ff[i] <= '0;
         end else begin
            canvas_ff[i] <= canvas_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_number_ff <= RowNumW'(cmd.row_sel);
         row_cells_ff  <= canvas_ff[cmd.row_sel];
         last_row_ff   <= (cmd.row_sel == LastRow);
      end
   end

   assign row_number = row_number_ff;
   assign row_cells  = row_cells_ff;
   assign last_row   = last_row_ff;

endmodule

// ===== hdl/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsp_ctrl
// Controller: accepts items, sequences a canvas dump, owns result valid.
// ----------------------------------------------------------------------------
module bsp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsp_pkg::status_type  status,
   output bsp_pkg::cmd_type     cmd
);
   import bsp_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StDump = 1'b1;

   logic                state_ff, state_in;
   logic [RowIdxW-1:0]  row_ff, row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept, out_free;

   assign req_ready = (state_ff == StIdle);
   assign accept    = req_valid && req_ready;
   // The result register can take a row if it is empty or being emptied now.
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      cmd.draw    = 1'b0;
      cmd.load    = 1'b0;
      cmd.clear   = 1'b0;
      cmd.row_sel = row_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (status.dump) begin
                  state_in = StDump;
                  row_in   = '0;
               end else begin
                  cmd.draw = 1'b1;
               end
            end
         end
         StDump: begin
            if (out_free) begin
               cmd.load = 1'b1;
               row_in   = row_ff + 1'b1;
               if (row_ff == LastRow) begin
                  cmd.clear = 1'b1;
                  state_in  = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (cmd.load && (row_ff == LastRow)))
      else $error("canvas cleared before the last row was loaded");

   a_idle_after_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (state_ff == StIdle))
      else $error("controller did not return to idle after a dump");

   a_draw_in_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.draw |-> (accept && (state_ff == StIdle)))
      else $error("draw issued without an accepted item");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still held");

   a_no_draw_and_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.draw && cmd.load))
      else $error("draw and dump active in the same cycle");
`endif

endmodule
